[hdl/prt_pkg.sv]
// Shared types and constants for the point range tracker.
package prt_pkg;

    localparam int OUT_W       = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic               restart;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic signed [31:0] z_coord;
        logic signed [31:0] intensity;
        logic               intensity_valid;
    } point_t;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] max_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_z;
        logic        [31:0] min_dist;
        logic        [31:0] max_dist;
        logic signed [31:0] min_intensity;
        logic signed [31:0] max_intensity;
        logic               intensity_seen;
    } range_set_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL,
        FR_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROOT,
        BK_FOLD
    } back_state_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

endpackage

[hdl/prt_if.sv]
// Request channels for points going in and range sets coming out.
interface prt_point_if;
    logic             valid;
    logic             ready;
    prt_pkg::point_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface prt_range_if;
    logic                 valid;
    logic                 ready;
    prt_pkg::range_set_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/prt_front.sv]
// Front end: takes a point, narrows its coordinates and saturates its intensity, and sums the squared coordinates.
module prt_front #(
    parameter int  COORD_WIDTH = 32,
    localparam int ENT_W       = 6 * COORD_WIDTH + 2
) (
    input  logic             clk,
    input  logic             rst_n,
    prt_point_if.sink        points,
    output logic             push_valid,
    input  logic             push_ready,
    output logic [ENT_W-1:0] push_data
);

    localparam int SUM_W = 2 * COORD_WIDTH;
    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF >>> (32 - COORD_WIDTH);
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000 >>> (32 - COORD_WIDTH);

    prt_pkg::front_state_t state_reg, state_next;
    prt_pkg::axis_t        step_reg, step_next;

    logic                          restart_reg;
    logic signed [COORD_WIDTH-1:0] x_reg, y_reg, z_reg;
    logic signed [COORD_WIDTH-1:0] inten_reg;
    logic                          ivalid_reg;
    logic        [SUM_W-1:0]       prod_reg;
    logic        [SUM_W-1:0]       sum_reg;

    logic                          take;
    logic signed [COORD_WIDTH-1:0] operand;
    logic signed [SUM_W-1:0]       square;
    logic signed [COORD_WIDTH-1:0] inten_sat;
    logic        [SUM_W-1:0]       push_sum;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            prt_pkg::FR_IDLE:
            begin
                if (points.valid)
                begin
                    state_next = prt_pkg::FR_MUL;
                end
            end
            prt_pkg::FR_MUL:
            begin
                if (step_reg == prt_pkg::AXIS_Z)
                begin
                    state_next = prt_pkg::FR_PUSH;
                end
            end
            prt_pkg::FR_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = prt_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = prt_pkg::FR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        points.ready = 1'b0;
        push_valid   = 1'b0;
        case (state_reg)
            prt_pkg::FR_IDLE:
            begin
                points.ready = 1'b1;
            end
            prt_pkg::FR_PUSH:
            begin
                push_valid = 1'b1;
            end
            default:
            begin
                points.ready = 1'b0;
                push_valid   = 1'b0;
            end
        endcase
    end

    assign take = points.valid && points.ready;

    always_comb
    begin
        case (step_reg)
            prt_pkg::AXIS_X: step_next = prt_pkg::AXIS_Y;
            prt_pkg::AXIS_Y: step_next = prt_pkg::AXIS_Z;
            default:         step_next = prt_pkg::AXIS_X;
        endcase
    end

    always_comb
    begin
        case (step_reg)
            prt_pkg::AXIS_X: operand = x_reg;
            prt_pkg::AXIS_Y: operand = y_reg;
            prt_pkg::AXIS_Z: operand = z_reg;
            default:         operand = '0;
        endcase
    end

    assign square = operand * operand;

    always_comb
    begin
        if (points.data.intensity > SAT_MAX)
        begin
            inten_sat = SAT_MAX[COORD_WIDTH-1:0];
        end
        else if (points.data.intensity < SAT_MIN)
        begin
            inten_sat = SAT_MIN[COORD_WIDTH-1:0];
        end
        else
        begin
            inten_sat = points.data.intensity[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prt_pkg::FR_IDLE;
            step_reg  <= prt_pkg::AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                step_reg <= prt_pkg::AXIS_X;
            end
            else if (state_reg == prt_pkg::FR_MUL)
            begin
                step_reg <= step_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            restart_reg <= points.data.restart;
            x_reg       <= points.data.x_coord[COORD_WIDTH-1:0];
            y_reg       <= points.data.y_coord[COORD_WIDTH-1:0];
            z_reg       <= points.data.z_coord[COORD_WIDTH-1:0];
            inten_reg   <= inten_sat;
            ivalid_reg  <= points.data.intensity_valid;
        end
        if (state_reg == prt_pkg::FR_MUL)
        begin
            prod_reg <= square;
            if (step_reg == prt_pkg::AXIS_X)
            begin
                sum_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_reg + prod_reg;
            end
        end
    end

    // The last square is still in the product register while the request waits.
    assign push_sum  = sum_reg + prod_reg;
    assign push_data = {restart_reg, x_reg, y_reg, z_reg, inten_reg, ivalid_reg, push_sum};

`ifndef NO_ASSERTIONS
    a_sum_of_squares: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> $signed({1'b0, push_sum}) ==
            x_reg * x_reg + y_reg * y_reg + z_reg * z_reg)
        else $error("Accumulated sum of squares does not match the captured point.");
`endif

endmodule

[hdl/prt_queue.sv]
// Two-entry queue between the front end and the back end.
module prt_queue #(
    parameter int WIDTH = 194
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(prt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(prt_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(prt_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(prt_pkg::QUEUE_DEPTH);

    logic [WIDTH-1:0] slot_reg [prt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_push_shows_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && count_reg == '0) |=> pop_valid)
        else $error("A request pushed into the empty queue did not appear at its head.");
`endif

endmodule

[hdl/prt_back.sv]
// Back end: square root of the sum of squares, range folding and the result register.
module prt_back #(
    parameter int  COORD_WIDTH = 32,
    parameter int  FRAC_BITS   = 16,
    localparam int ENT_W       = 6 * COORD_WIDTH + 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  logic [ENT_W-1:0] pop_data,
    prt_range_if.source      ranges
);

    localparam int CW    = COORD_WIDTH;
    localparam int SUM_W = 2 * CW;
    localparam int CNT_W = $clog2(CW);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CW - 1);
    localparam logic signed [CW-1:0] S_MAX = {1'b0, {(CW - 1){1'b1}}};
    localparam logic signed [CW-1:0] S_MIN = {1'b1, {(CW - 1){1'b0}}};
    localparam logic [prt_pkg::OUT_W-1:0] ONE_Q = prt_pkg::OUT_W'(1) << FRAC_BITS;

    prt_pkg::back_state_t state_reg, state_next;

    logic                 restart_e;
    logic signed [CW-1:0] x_e, y_e, z_e, inten_e;
    logic                 ivalid_e;
    logic [SUM_W-1:0]     rad_reg;
    logic [CW:0]          rem_reg;
    logic [CW-1:0]        root_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic signed [CW-1:0] lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg, lo_z_reg, hi_z_reg;
    logic signed [CW-1:0] lo_i_reg, hi_i_reg;
    logic [CW-1:0]        lo_d_reg, hi_d_reg;
    logic                 present_reg;

    logic signed [CW-1:0] lo_x_b, hi_x_b, lo_y_b, hi_y_b, lo_z_b, hi_z_b, lo_i_b, hi_i_b;
    logic [CW-1:0]        lo_d_b, hi_d_b;
    logic signed [CW-1:0] lo_x_next, hi_x_next, lo_y_next, hi_y_next, lo_z_next, hi_z_next;
    logic signed [CW-1:0] lo_i_next, hi_i_next;
    logic [CW-1:0]        lo_d_next, hi_d_next;
    logic                 present_next;

    logic [CW+1:0]        rem_sh, trial;
    logic                 fits;
    logic                 take, fold_en, out_valid_reg;
    prt_pkg::range_set_t  res_reg, res_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            prt_pkg::BK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = prt_pkg::BK_ROOT;
                end
            end
            prt_pkg::BK_ROOT:
            begin
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = prt_pkg::BK_FOLD;
                end
            end
            prt_pkg::BK_FOLD:
            begin
                if (!out_valid_reg || ranges.ready)
                begin
                    state_next = prt_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = prt_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop_ready = 1'b0;
        fold_en   = 1'b0;
        case (state_reg)
            prt_pkg::BK_IDLE:
            begin
                pop_ready = 1'b1;
            end
            prt_pkg::BK_FOLD:
            begin
                fold_en = !out_valid_reg || ranges.ready;
            end
            default:
            begin
                pop_ready = 1'b0;
                fold_en   = 1'b0;
            end
        endcase
    end

    assign take = pop_valid && pop_ready;

    // One root bit per cycle: bring down two radicand bits and try 4 * root + 1.
    assign rem_sh = {rem_reg[CW-1:0], rad_reg[SUM_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prt_pkg::BK_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == prt_pkg::BK_ROOT)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            {restart_e, x_e, y_e, z_e, inten_e, ivalid_e, rad_reg} <= pop_data;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (state_reg == prt_pkg::BK_ROOT)
        begin
            rad_reg  <= {rad_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= fits ? (CW + 1)'(rem_sh - trial) : (CW + 1)'(rem_sh);
            root_reg <= {root_reg[CW-2:0], fits};
        end
    end

    always_comb
    begin
        lo_x_b = restart_e ? S_MAX : lo_x_reg;
        hi_x_b = restart_e ? S_MIN : hi_x_reg;
        lo_y_b = restart_e ? S_MAX : lo_y_reg;
        hi_y_b = restart_e ? S_MIN : hi_y_reg;
        lo_z_b = restart_e ? S_MAX : lo_z_reg;
        hi_z_b = restart_e ? S_MIN : hi_z_reg;
        lo_i_b = restart_e ? S_MAX : lo_i_reg;
        hi_i_b = restart_e ? S_MIN : hi_i_reg;
        lo_d_b = restart_e ? '1 : lo_d_reg;
        hi_d_b = restart_e ? '0 : hi_d_reg;

        lo_x_next = (x_e < lo_x_b) ? x_e : lo_x_b;
        hi_x_next = (x_e > hi_x_b) ? x_e : hi_x_b;
        lo_y_next = (y_e < lo_y_b) ? y_e : lo_y_b;
        hi_y_next = (y_e > hi_y_b) ? y_e : hi_y_b;
        lo_z_next = (z_e < lo_z_b) ? z_e : lo_z_b;
        hi_z_next = (z_e > hi_z_b) ? z_e : hi_z_b;
        lo_d_next = (root_reg < lo_d_b) ? root_reg : lo_d_b;
        hi_d_next = (root_reg > hi_d_b) ? root_reg : hi_d_b;

        if (ivalid_e)
        begin
            lo_i_next = (inten_e < lo_i_b) ? inten_e : lo_i_b;
            hi_i_next = (inten_e > hi_i_b) ? inten_e : hi_i_b;
        end
        else
        begin
            lo_i_next = lo_i_b;
            hi_i_next = hi_i_b;
        end
        present_next = ivalid_e || (present_reg && !restart_e);
    end

    // Coordinates and distance are folded with every point, so only intensity can be unseen.
    always_comb
    begin
        res_next.min_x          = prt_pkg::OUT_W'(lo_x_next);
        res_next.max_x          = prt_pkg::OUT_W'(hi_x_next);
        res_next.min_y          = prt_pkg::OUT_W'(lo_y_next);
        res_next.max_y          = prt_pkg::OUT_W'(hi_y_next);
        res_next.min_z          = prt_pkg::OUT_W'(lo_z_next);
        res_next.max_z          = prt_pkg::OUT_W'(hi_z_next);
        res_next.min_dist       = prt_pkg::OUT_W'(lo_d_next);
        res_next.max_dist       = prt_pkg::OUT_W'(hi_d_next);
        res_next.min_intensity  = present_next ? prt_pkg::OUT_W'(lo_i_next) : '0;
        res_next.max_intensity  = present_next ? prt_pkg::OUT_W'(hi_i_next) : ONE_Q;
        res_next.intensity_seen = present_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_x_reg      <= S_MAX;
            hi_x_reg      <= S_MIN;
            lo_y_reg      <= S_MAX;
            hi_y_reg      <= S_MIN;
            lo_z_reg      <= S_MAX;
            hi_z_reg      <= S_MIN;
            lo_i_reg      <= S_MAX;
            hi_i_reg      <= S_MIN;
            lo_d_reg      <= '1;
            hi_d_reg      <= '0;
            present_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fold_en)
            begin
                lo_x_reg      <= lo_x_next;
                hi_x_reg      <= hi_x_next;
                lo_y_reg      <= lo_y_next;
                hi_y_reg      <= hi_y_next;
                lo_z_reg      <= lo_z_next;
                hi_z_reg      <= hi_z_next;
                lo_i_reg      <= lo_i_next;
                hi_i_reg      <= hi_i_next;
                lo_d_reg      <= lo_d_next;
                hi_d_reg      <= hi_d_next;
                present_reg   <= present_next;
                out_valid_reg <= 1'b1;
            end
            else if (ranges.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fold_en)
        begin
            res_reg <= res_next;
        end
    end

    assign ranges.valid = out_valid_reg;
    assign ranges.data  = res_reg;

`ifndef NO_ASSERTIONS
    a_dist_order: assert property (@(posedge clk) disable iff (!rst_n)
        ranges.valid |-> ranges.data.min_dist <= ranges.data.max_dist)
        else $error("Reported distance range is inverted.");

    a_x_order: assert property (@(posedge clk) disable iff (!rst_n)
        ranges.valid |-> $signed(ranges.data.min_x) <= $signed(ranges.data.max_x))
        else $error("Reported x range is inverted.");

    a_intensity_order: assert property (@(posedge clk) disable iff (!rst_n)
        (ranges.valid && ranges.data.intensity_seen) |->
            $signed(ranges.data.min_intensity) <= $signed(ranges.data.max_intensity))
        else $error("Reported intensity range is inverted although intensity was seen.");
`endif

endmodule

[hdl/point_range_tracker_top.sv]
// Point range tracker: running minimum and maximum of lidar point coordinates,
// distance and intensity. Each request on points carries x, y, z and an intensity
// in signed fixed point; each request on ranges returns the resolved ranges after
// that point has been folded in, with an unseen intensity range reported as 0 to
// 1.0. The front end takes a point and then squares x, y and z in turn on a
// single shared multiplier, summing the squares, then hands it through a two-entry
// queue to the back end. The back end computes the square root one bit per cycle
// and then folds the point in, taking no new point until that fold is done; the
// square root unit sets the sustained rate. A result may wait on ranges while the
// next point is already being worked on.
module point_range_tracker_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    prt_point_if.sink    points,
    prt_range_if.source  ranges
);

    localparam int ENT_W = 6 * COORD_WIDTH + 2;

    logic             push_valid, push_ready;
    logic [ENT_W-1:0] push_data;
    logic             pop_valid, pop_ready;
    logic [ENT_W-1:0] pop_data;

    prt_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .points     (points),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    prt_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    prt_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .ranges    (ranges)
    );

endmodule

[tb/sv/prt_tb_pkg.sv]
// Range scoreboard for the point range tracker: predicts and checks range sets.
package prt_tb_pkg;

    import prt_pkg::*;

    class range_scoreboard;

        logic signed [31:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z, lo_int, hi_int;
        logic        [31:0] lo_dist, hi_dist;
        logic               int_present;
        range_set_t         expected_ranges[$];
        int                 failures;
        int                 checked;

        function new();
            clear_ranges();
            failures = 0;
            checked  = 0;
        endfunction

        function void clear_ranges();
            lo_x        = 32'sh7FFF_FFFF;
            hi_x        = 32'sh8000_0000;
            lo_y        = 32'sh7FFF_FFFF;
            hi_y        = 32'sh8000_0000;
            lo_z        = 32'sh7FFF_FFFF;
            hi_z        = 32'sh8000_0000;
            lo_int      = 32'sh7FFF_FFFF;
            hi_int      = 32'sh8000_0000;
            lo_dist     = 32'hFFFF_FFFF;
            hi_dist     = 32'h0000_0000;
            int_present = 1'b0;
        endfunction

        function int pending();
            return expected_ranges.size();
        endfunction

        // Truncated integer square root of x*x + y*y + z*z, which keeps the
        // fraction bits of the coordinates.
        function logic [31:0] euclid_dist(point_t p);
            longint      sx, sy, sz;
            logic [63:0] rem, root, probe;
            sx    = p.x_coord;
            sy    = p.y_coord;
            sz    = p.z_coord;
            rem   = $unsigned(sx * sx) + $unsigned(sy * sy) + $unsigned(sz * sz);
            root  = 64'd0;
            probe = 64'h4000_0000_0000_0000;
            while (probe > rem)
                probe = probe >> 2;
            while (probe != 64'd0)
            begin
                if (rem >= root + probe)
                begin
                    rem  = rem - (root + probe);
                    root = (root >> 1) + probe;
                end
                else
                begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            return root[31:0];
        endfunction

        function void fold_signed(ref logic signed [31:0] lo, ref logic signed [31:0] hi,
                                  input logic signed [31:0] v);
            if (v < lo)
                lo = v;
            if (v > hi)
                hi = v;
        endfunction

        // A range that was never observed reads as 0 to 1.0.
        function void resolve_signed(input logic signed [31:0] lo, hi,
                                     output logic signed [31:0] rmin, rmax);
            if (lo <= hi)
            begin
                rmin = lo;
                rmax = hi;
            end
            else
            begin
                rmin = 32'sd0;
                rmax = 32'sh0001_0000;
            end
        endfunction

        function void note_point(point_t p);
            range_set_t  r;
            logic [31:0] pt_dist;
            if (p.restart)
                clear_ranges();
            pt_dist = euclid_dist(p);
            fold_signed(lo_x, hi_x, p.x_coord);
            fold_signed(lo_y, hi_y, p.y_coord);
            fold_signed(lo_z, hi_z, p.z_coord);
            if (pt_dist < lo_dist)
                lo_dist = pt_dist;
            if (pt_dist > hi_dist)
                hi_dist = pt_dist;
            if (p.intensity_valid)
            begin
                fold_signed(lo_int, hi_int, p.intensity);
                int_present = 1'b1;
            end
            resolve_signed(lo_x, hi_x, r.min_x, r.max_x);
            resolve_signed(lo_y, hi_y, r.min_y, r.max_y);
            resolve_signed(lo_z, hi_z, r.min_z, r.max_z);
            if (lo_dist <= hi_dist)
            begin
                r.min_dist = lo_dist;
                r.max_dist = hi_dist;
            end
            else
            begin
                r.min_dist = 32'd0;
                r.max_dist = 32'h0001_0000;
            end
            resolve_signed(lo_int, hi_int, r.min_intensity, r.max_intensity);
            r.intensity_seen = int_present;
            expected_ranges.insert(expected_ranges.size(), r);
        endfunction

        function void compare_word(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %h, actual %h", field, want, got);
                failures++;
            end
        endfunction

        function void check_range(range_set_t got);
            range_set_t want;
            if (expected_ranges.size() == 0)
            begin
                $error("range set arrived with no point pending: %h", got);
                failures++;
                return;
            end
            want = expected_ranges.pop_front();
            checked++;
            compare_word("min_x", want.min_x, got.min_x);
            compare_word("max_x", want.max_x, got.max_x);
            compare_word("min_y", want.min_y, got.min_y);
            compare_word("max_y", want.max_y, got.max_y);
            compare_word("min_z", want.min_z, got.min_z);
            compare_word("max_z", want.max_z, got.max_z);
            compare_word("min_dist", want.min_dist, got.min_dist);
            compare_word("max_dist", want.max_dist, got.max_dist);
            compare_word("min_intensity", want.min_intensity, got.min_intensity);
            compare_word("max_intensity", want.max_intensity, got.max_intensity);
            compare_word("intensity_seen", {31'd0, want.intensity_seen},
                         {31'd0, got.intensity_seen});
        endfunction

    endclass

endpackage

[tb/sv/tb.sv]
// Testbench top for point_range_tracker_top: drives points, checks range sets.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import prt_pkg::*;
    import prt_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_POINTS  = 836;

    typedef enum int {
        FLOW_OPEN,
        FLOW_COIN,
        FLOW_COMB,
        FLOW_HOLD
    } stall_mode_t;

    logic            clk = 1'b0;
    logic            rst_n;
    int              idle_cycles = 0;
    int              points_taken = 0;
    int              restarts_taken = 0;
    int              lit_points = 0;
    range_scoreboard sb;

    prt_point_if pt_ch ();
    prt_range_if rg_ch ();

    point_range_tracker_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (pt_ch),
        .ranges (rg_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (pt_ch.valid && pt_ch.ready)
        begin
            sb.note_point(pt_ch.data);
            points_taken++;
            if (pt_ch.data.restart)
                restarts_taken++;
            if (pt_ch.data.intensity_valid)
                lit_points++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rg_ch.valid && rg_ch.ready)
            sb.check_range(rg_ch.data);
    end

    always @(posedge clk)
    begin
        if ((pt_ch.valid && pt_ch.ready) || (rg_ch.valid && rg_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL point_range_tracker_top");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        stall_mode_t mode;
        int          span;
        int          k;
        logic        go;
        rg_ch.ready <= 1'b0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(16, 160);
            for (k = 0; k < span; k++)
            begin
                @(posedge clk);
                case (mode)
                    FLOW_OPEN: go = 1'b1;
                    FLOW_COIN: go = $urandom_range(0, 1) == 1;
                    FLOW_COMB: go = (k % 6) > 1;
                    default:   go = k > span / 2;
                endcase
                rg_ch.ready <= go;
            end
        end
    end

    function automatic point_t make_point(logic restart, logic [31:0] x, y, z, inten,
                                          logic inten_valid);
        point_t p;
        p.restart         = restart;
        p.x_coord         = x;
        p.y_coord         = y;
        p.z_coord         = z;
        p.intensity       = inten;
        p.intensity_valid = inten_valid;
        return p;
    endfunction

    function automatic logic [31:0] pick_coord();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                v = $urandom_range(0, 32'h001F_FFFF);
                return v - 32'h0010_0000;
            end
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            3:
            begin
                v = $urandom_range(0, 32'h0FFF_FFFF);
                return v - 32'h0800_0000;
            end
            default:
                return $urandom();
        endcase
    endfunction

    // Called just after a rising edge; returns just after the edge that took the point.
    task automatic push_point(point_t p);
        pt_ch.valid <= 1'b1;
        pt_ch.data  <= p;
        do
            @(posedge clk);
        while (pt_ch.ready !== 1'b1);
    endtask

    task automatic hold_off(int cycles);
        pt_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_ranges();
        pt_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        int   n;
        int   burst_left;
        logic restart;
        logic dark;
        logic inten_valid;
        sb = new();
        rst_n       <= 1'b0;
        pt_ch.valid <= 1'b0;
        pt_ch.data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_point(make_point(1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
        push_point(make_point(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 1'b1));
        push_point(make_point(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 1'b1));
        push_point(make_point(1'b0, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0, 1'b0));
        push_point(make_point(1'b0, 32'h1, 32'h1, 32'h1, 32'hFFFF_FFFF, 1'b0));
        hold_off(3);
        push_point(make_point(1'b1, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h1234_5678, 1'b0));
        push_point(make_point(1'b0, 32'h0, 32'hFFFF_0000, 32'h0001_0000,
                              32'h5555_5555, 1'b0));
        push_point(make_point(1'b0, 32'h2, 32'h3, 32'h6, 32'hFFFF_0000, 1'b1));
        push_point(make_point(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 1'b1));
        push_point(make_point(1'b0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1));
        push_point(make_point(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                              32'h8000_0000, 1'b1));
        push_point(make_point(1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                              32'hAAAA_AAAA, 1'b0));
        push_point(make_point(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h7FFF_FFFF, 1'b1));
        push_point(make_point(1'b1, 32'h0, 32'h0, 32'h8000_0000, 32'h0001_0000, 1'b1));
        drain_ranges();

        dark       = 1'b0;
        burst_left = $urandom_range(1, 40);
        for (n = 0; n < RANDOM_POINTS; n++)
        begin
            restart = $urandom_range(0, 29) == 0;
            if (restart)
                dark = $urandom_range(0, 3) == 0;
            inten_valid = dark ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 3) != 0);
            push_point(make_point(restart, pick_coord(), pick_coord(), pick_coord(),
                                  pick_coord(), inten_valid));
            if (n == 300 || n == 600)
            begin
                drain_ranges();
            end
            else if (--burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                hold_off($urandom_range(0, 4) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12));
            end
        end
        drain_ranges();
        repeat (60) @(posedge clk);

        $display("Run covered %0d points, %0d of them restarts and %0d with intensity,",
                 points_taken, restarts_taken, lit_points);
        $display("and compared %0d range sets field by field.", sb.checked);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASS point_range_tracker_top");
        else
            $display("FAIL point_range_tracker_top");
        $finish;
    end

endmodule
